// ----- rtl/core/nlsc_pkg.sv -----
// nlsc_pkg: shared types and constants of the length-prefix to start-code converter
// used by every module under rtl/core, depends on nothing
`default_nettype none

package nlsc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // start code is four bytes, step index of its last byte
    localparam logic [2:0] SC_LEN       = 3'd4;
    localparam logic [2:0] SC_LAST_STEP = 3'd3;

    localparam logic [2:0] PREFIX_MIN = 3'd1;
    localparam logic [2:0] PREFIX_MAX = 3'd4;

    typedef enum logic {
        REG_WRAPPED_MODE = 1'b0,
        REG_PREFIX_BYTES = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic       wrapped_mode;
        logic [2:0] prefix_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unit_start;
        logic       truncated;
        logic       last_of_run;
    } out_word_t;

    // one queue entry: what the back end has to emit for one input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       has_sc;
        logic       has_trunc;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/nlsc_front.sv -----
// nlsc_front: accepts input words, tracks prefix and payload state, issues commands
// depends on nlsc_pkg
`default_nettype none

module nlsc_front
    import nlsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     accept,
    input  wire in_word_t in_word,
    output logic          push,
    output cmd_t          cmd
);

    logic        in_payload_reg,   in_payload_next;
    logic [1:0]  prefix_count_reg, prefix_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] bytes_left_reg,   bytes_left_next;

    logic [2:0]  need;
    logic [2:0]  have;
    logic [31:0] acc;
    logic [31:0] bl_dec;

    always_comb begin
        if (cfg.prefix_bytes < PREFIX_MIN) begin
            need = PREFIX_MIN;
        end else if (cfg.prefix_bytes > PREFIX_MAX) begin
            need = PREFIX_MAX;
        end else begin
            need = cfg.prefix_bytes;
        end
    end

    assign have   = {1'b0, prefix_count_reg} + 3'd1;
    assign acc    = {length_accum_reg[23:0], in_word.in_byte};
    assign bl_dec = bytes_left_reg - 32'd1;

    always_comb begin
        in_payload_next   = in_payload_reg;
        prefix_count_next = prefix_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        cmd.data_byte     = in_word.in_byte;
        cmd.has_data      = 1'b0;
        cmd.has_sc        = 1'b0;
        cmd.has_trunc     = 1'b0;

        if (!cfg.wrapped_mode) begin
            cmd.has_data = 1'b1;
        end else if (in_payload_reg) begin
            cmd.has_data    = 1'b1;
            bytes_left_next = bl_dec;
            in_payload_next = (bl_dec != 32'd0);
            cmd.has_trunc   = in_word.packet_end && (bl_dec != 32'd0);
        end else if (have >= need) begin
            cmd.has_sc        = 1'b1;
            in_payload_next   = (acc != 32'd0);
            if (acc != 32'd0) begin
                bytes_left_next = acc;
            end
            prefix_count_next = 2'd0;
            length_accum_next = 32'd0;
            cmd.has_trunc     = in_word.packet_end && (acc != 32'd0);
        end else begin
            prefix_count_next = have[1:0];
            length_accum_next = acc;
            cmd.has_trunc     = in_word.packet_end;
        end

        if (in_word.packet_end) begin
            in_payload_next   = 1'b0;
            prefix_count_next = 2'd0;
            length_accum_next = 32'd0;
            bytes_left_next   = 32'd0;
        end
    end

    assign push = accept && (cmd.has_data || cmd.has_sc || cmd.has_trunc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg   <= 1'b0;
            prefix_count_reg <= 2'd0;
            length_accum_reg <= 32'd0;
            bytes_left_reg   <= 32'd0;
        end else if (accept) begin
            in_payload_reg   <= in_payload_next;
            prefix_count_reg <= prefix_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

`ifndef ASSERT_OFF
    a_payload_no_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (prefix_count_reg == 2'd0))
        else $error("prefix count nonzero inside payload");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nlsc_queue.sv -----
// nlsc_queue: short command queue between front and back end
// depends on nlsc_pkg
`default_nettype none

module nlsc_queue
    import nlsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nlsc_back.sv -----
// nlsc_back: expands queued commands into result words through an output register
// depends on nlsc_pkg
`default_nettype none

module nlsc_back
    import nlsc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_word_t m_data
);

    logic      [2:0] step_reg, step_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_data_reg;
    out_word_t       word;

    logic [2:0] base_len;
    logic [2:0] total;
    logic       load;
    logic       emit;
    logic       is_last;

    always_comb begin
        if (cmd.has_data) begin
            base_len = 3'd1;
        end else if (cmd.has_sc) begin
            base_len = SC_LEN;
        end else begin
            base_len = 3'd0;
        end
    end

    assign total   = base_len + {2'b00, cmd.has_trunc};
    assign load    = !m_valid_reg || m_ready;
    assign emit    = cmd_valid && load;
    assign is_last = (step_reg == total - 3'd1);
    assign pop     = emit && is_last;

    always_comb begin
        word.out_byte    = SC_ZERO;
        word.byte_valid  = 1'b0;
        word.unit_start  = 1'b0;
        word.truncated   = 1'b0;
        word.last_of_run = is_last;
        if (step_reg < base_len) begin
            word.byte_valid = 1'b1;
            if (cmd.has_data) begin
                word.out_byte = cmd.data_byte;
            end else begin
                word.out_byte   = (step_reg == SC_LAST_STEP) ? SC_ONE : SC_ZERO;
                word.unit_start = (step_reg == 3'd0);
            end
        end else begin
            word.truncated = 1'b1;
        end
    end

    assign step_next    = emit ? (is_last ? 3'd0 : step_reg + 3'd1) : step_reg;
    assign m_valid_next = load ? emit : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid_reg && m_data_reg.last_of_run))
        else $error("command retired without last_of_run word");
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg <= SC_LEN) && (!cmd_valid || step_reg < total || total == 3'd0))
        else $error("step counter beyond command length");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nal_length_prefix_to_start_code_top.sv -----
// converter top: length-prefixed nal units to start-code framed byte stream
// first result word passes through the command queue and then the output register
// one input word per cycle; one output word per cycle while m_ready is high, a start code
// takes four output words (five with a truncation flag), absorbed by the command queue
// input stalls only when the queue of QUEUE_DEPTH commands is full
// synchronous active-low reset clears state, queue, output, wrapped_mode 0, prefix_bytes 4
// depends on nlsc_pkg, nlsc_front, nlsc_queue, nlsc_back
`default_nettype none

module nal_length_prefix_to_start_code_top
    import nlsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_word_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data
);

    cfg_t cfg_reg;
    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic full;
    logic empty;
    cmd_t head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrapped_mode <= 1'b0;
            cfg_reg.prefix_bytes <= PREFIX_MAX;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_WRAPPED_MODE: cfg_reg.wrapped_mode <= cfg_wdata[0];
                REG_PREFIX_BYTES: cfg_reg.prefix_bytes <= cfg_wdata;
            endcase
        end
    end

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    nlsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .in_word (s_data),
        .push    (push),
        .cmd     (push_cmd)
    );

    nlsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    nlsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!empty),
        .cmd       (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// nal_length_prefix_to_start_code_top testbench: directed table, burst, random packets
// predicts the framed stream itself and checks every result word; depends on nlsc_pkg
`default_nettype none

module testbench;
    import nlsc_pkg::*;

    localparam int ITEM_TARGET    = 170;
    localparam int CALM_ITEMS     = 30;
    localparam int BURST_ITEMS    = 16;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int TIMEOUT_UNITS  = 400000;
    localparam out_word_t NO_WORD = '0;
    localparam in_word_t NO_IN    = '0;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        reg_index_t idx;
        logic [2:0] val;
        in_word_t   word;
        logic       typed;
        out_word_t  lead;
    } row_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_wr_en = 1'b0;
    reg_index_t cfg_index = REG_WRAPPED_MODE;
    logic [2:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_word_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_word_t  m_data;

    logic      tag_typed = 1'b0;
    out_word_t tag_lead  = '0;

    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    int sent       = 0;
    int mismatches = 0;

    out_word_t framed_q[$];

    // converter state and settings as the block should hold them
    logic        cv_wrapped   = 1'b0;
    logic [2:0]  cv_prefix    = PREFIX_MAX;
    logic        cv_in_unit   = 1'b0;
    logic [1:0]  cv_pfx_cnt   = '0;
    logic [31:0] cv_len_acc   = '0;
    logic [31:0] cv_remaining = '0;

    row_t dir_rows [0:32] = '{
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'hA5, 1'b0}, 1'b1, '{8'hA5, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ROW_CFG,  REG_WRAPPED_MODE, 3'd1, NO_IN,          1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd1, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h02, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'hFF, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h01, 1'b1}, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd4, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h03, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h11, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h22, 1'b1}, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd0, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h80, 1'b1}, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd7, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h01, 1'b0}, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd2, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'hAB, 1'b1}, 1'b0, NO_WORD},
        '{ROW_CFG,  REG_PREFIX_BYTES, 3'd3, NO_IN,          1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h00, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h01, 1'b0}, 1'b0, NO_WORD},
        '{ROW_WORD, REG_WRAPPED_MODE, 3'd0, '{8'h7E, 1'b1}, 1'b0, NO_WORD}
    };

    nal_length_prefix_to_start_code_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic out_word_t stream_word(logic [7:0] b, logic v, logic st, logic tr);
        out_word_t r;
        r = '{b, v, st, tr, 1'b0};
        return r;
    endfunction

    function automatic string word_str(out_word_t r);
        return $sformatf("byte %h valid %b start %b trunc %b last %b",
                         r.out_byte, r.byte_valid, r.unit_start, r.truncated, r.last_of_run);
    endfunction

    function automatic logic [2:0] prefix_size();
        if (cv_prefix < PREFIX_MIN)
            return PREFIX_MIN;
        if (cv_prefix > PREFIX_MAX)
            return PREFIX_MAX;
        return cv_prefix;
    endfunction

    function automatic void frame_byte(in_word_t w, logic typed, out_word_t lead);
        out_word_t  run[$];
        out_word_t  r;
        logic [2:0] need;
        logic [2:0] have;
        need = prefix_size();
        if (!cv_wrapped) begin
            run.push_back(stream_word(w.in_byte, 1'b1, 1'b0, 1'b0));
        end else begin
            if (cv_in_unit) begin
                run.push_back(stream_word(w.in_byte, 1'b1, 1'b0, 1'b0));
                cv_remaining = cv_remaining - 32'd1;
                if (cv_remaining == 0)
                    cv_in_unit = 1'b0;
            end else begin
                have = {1'b0, cv_pfx_cnt} + 3'd1;
                cv_len_acc = {cv_len_acc[23:0], w.in_byte};
                if (have >= need) begin
                    run.push_back(stream_word(SC_ZERO, 1'b1, 1'b1, 1'b0));
                    run.push_back(stream_word(SC_ZERO, 1'b1, 1'b0, 1'b0));
                    run.push_back(stream_word(SC_ZERO, 1'b1, 1'b0, 1'b0));
                    run.push_back(stream_word(SC_ONE, 1'b1, 1'b0, 1'b0));
                    if (cv_len_acc != 0) begin
                        cv_in_unit   = 1'b1;
                        cv_remaining = cv_len_acc;
                    end
                    cv_pfx_cnt = '0;
                    cv_len_acc = '0;
                end else begin
                    cv_pfx_cnt = have[1:0];
                end
            end
            if (w.packet_end && (cv_in_unit || cv_pfx_cnt != 0))
                run.push_back(stream_word(8'h00, 1'b0, 1'b0, 1'b1));
        end
        if (w.packet_end) begin
            cv_in_unit   = 1'b0;
            cv_pfx_cnt   = '0;
            cv_len_acc   = '0;
            cv_remaining = '0;
        end
        foreach (run[i]) begin
            r = run[i];
            r.last_of_run = (i == run.size() - 1);
            if (typed && i == 0)
                r = lead;
            framed_q.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cv_wrapped   = 1'b0;
            cv_prefix    = PREFIX_MAX;
            cv_in_unit   = 1'b0;
            cv_pfx_cnt   = '0;
            cv_len_acc   = '0;
            cv_remaining = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (framed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: %s", word_str(m_data));
                end else begin
                    if (m_data !== framed_q[0]) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected %s, got %s",
                                     word_str(framed_q[0]), word_str(m_data));
                    end
                    void'(framed_q.pop_front());
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WRAPPED_MODE: cv_wrapped = cfg_wdata[0];
                    REG_PREFIX_BYTES: cv_prefix  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                frame_byte(s_data, tag_typed, tag_lead);
        end
    end

    initial begin : result_ready
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input in_word_t w, input logic typed, input out_word_t lead);
        int gap;
        if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= w;
        tag_typed <= typed;
        tag_lead  <= lead;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (sent >= ITEM_TARGET - CALM_ITEMS)
            calm = 1'b1;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (framed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [2:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        in_word_t    pkt[$];
        in_word_t    w;
        logic [31:0] len;
        int eff, npk, nunits, pick, n, cut;
        bit huge;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].lead);
            end
        end

        // plain burst against a stalled receiver
        settle();
        write_reg(REG_WRAPPED_MODE, 3'd0);
        hold_req = 1'b1;
        for (int b = 0; b < BURST_ITEMS; b++)
            send_word('{8'($urandom), (b == BURST_ITEMS - 1)}, 1'b0, NO_WORD);

        while (sent < ITEM_TARGET) begin
            settle();
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_WRAPPED_MODE,
                          {2'($urandom_range(0, 3)), 1'($urandom_range(0, 4) != 0)});
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_PREFIX_BYTES, ($urandom_range(0, 4) == 0) ?
                          3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4)));
            eff = prefix_size();
            npk = $urandom_range(1, 3);
            for (int p = 0; p < npk; p++) begin
                pkt.delete();
                if (!cv_wrapped || $urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, 12);
                    repeat (n) pkt.push_back('{8'($urandom), 1'b0});
                end else begin
                    nunits = $urandom_range(1, 3);
                    for (int u = 0; u < nunits; u++) begin
                        pick = $urandom_range(0, 15);
                        huge = (pick == 0);
                        if (huge)
                            len = $urandom;
                        else if (pick < 3)
                            len = 0;
                        else
                            len = $urandom_range(1, 10);
                        if (eff < 4)
                            len = len & ((32'd1 << (8 * eff)) - 32'd1);
                        for (int k = eff - 1; k >= 0; k--)
                            pkt.push_back('{8'(len >> (8 * k)), 1'b0});
                        n = huge ? $urandom_range(0, 6) : int'(len);
                        repeat (n) pkt.push_back('{8'($urandom), 1'b0});
                        if (huge)
                            break;
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        cut = $urandom_range(1, pkt.size());
                        while (pkt.size() > cut) void'(pkt.pop_back());
                    end
                end
                // an open packet at the end of a phase carries state into new settings
                if (p != npk - 1 || $urandom_range(0, 5) != 0) begin
                    w = pkt[pkt.size() - 1];
                    w.packet_end = 1'b1;
                    pkt[pkt.size() - 1] = w;
                end
                foreach (pkt[j]) send_word(pkt[j], 1'b0, NO_WORD);
            end
        end

        settle();
        if (mismatches == 0 && framed_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_UNITS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
